// ----- design/dda_pkg.sv -----
// shared types, constants and calendar helpers of the date arithmetic unit
package dda_pkg;

   // field widths
   localparam int TYPE_W  = 2;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 20;
   localparam int DIFF_W  = 23;
   localparam int STAT_W  = 2;

   // day accumulator, signed, holds ordinals up to the top of the year field plus a count
   localparam int ACC_W = 24;
   // year walker, reaches past the year field when a move runs out of range
   localparam int YEAR_CNT_W = 16;

   localparam int YEAR_MAX_DEFAULT = 9999;
   localparam int FIELD_YEAR_TOP   = 16383;
   localparam int MONTHS_PER_YEAR  = 12;
   localparam int BLOCK_YEARS      = 400;
   localparam int BLOCK_DAYS       = 146097;
   localparam int CENTURY_YEARS    = 100;

   localparam logic signed [ACC_W-1:0] DIFF_HIGH = 24'sd4194303;
   localparam logic signed [ACC_W-1:0] DIFF_LOW  = -24'sd4194304;

   // request types
   localparam logic [TYPE_W-1:0] OP_ADD   = 2'd0;
   localparam logic [TYPE_W-1:0] OP_SUB   = 2'd1;
   localparam logic [TYPE_W-1:0] OP_DIFF  = 2'd2;
   localparam logic [TYPE_W-1:0] OP_CHECK = 2'd3;

   // result status
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

   typedef enum logic [3:0] {
      ALU_PASS     = 4'd0,
      ALU_BLK_ADD  = 4'd1,
      ALU_YEAR_ADD = 4'd2,
      ALU_MON_ADD  = 4'd3,
      ALU_DAY_ADD  = 4'd4,
      ALU_CNT_ADD  = 4'd5,
      ALU_CNT_SUB  = 4'd6,
      ALU_DIFF     = 4'd7,
      ALU_BLK_SUB  = 4'd8,
      ALU_YEAR_SUB = 4'd9,
      ALU_MON_SUB  = 4'd10
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic                 leap;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [COUNT_W-1:0]   cnt;
   } alu_ctl_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum;
      logic                    neg;
   } alu_res_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- design/dda_req_if.sv -----
// request channel of the date arithmetic unit
interface dda_req_if;
   logic                               valid;
   logic                               ready;
   logic [dda_pkg::TYPE_W-1:0]         req_type;
   logic [dda_pkg::DAY_W-1:0]          day;
   logic [dda_pkg::MONTH_W-1:0]        month;
   logic [dda_pkg::YEAR_W-1:0]         year;
   logic [dda_pkg::COUNT_W-1:0]        day_count;
   logic [dda_pkg::DAY_W-1:0]          other_day;
   logic [dda_pkg::MONTH_W-1:0]        other_month;
   logic [dda_pkg::YEAR_W-1:0]         other_year;

   modport source (output valid, req_type, day, month, year, day_count,
                   other_day, other_month, other_year, input ready);
   modport sink   (input valid, req_type, day, month, year, day_count,
                   other_day, other_month, other_year, output ready);
endinterface

// ----- design/dda_rsp_if.sv -----
// response channel of the date arithmetic unit
interface dda_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dda_pkg::DAY_W-1:0]          out_day;
   logic [dda_pkg::MONTH_W-1:0]        out_month;
   logic [dda_pkg::YEAR_W-1:0]         out_year;
   logic signed [dda_pkg::DIFF_W-1:0]  day_difference;
   logic [dda_pkg::STAT_W-1:0]         status;

   modport source (output valid, out_day, out_month, out_year, day_difference, status,
                   input ready);
   modport sink   (input valid, out_day, out_month, out_year, day_difference, status,
                   output ready);
endinterface

// ----- design/dda_alu.sv -----
// shared day adder with its operand select
module dda_alu (
   input  dda_pkg::alu_ctl_type               ctl,
   input  logic signed [dda_pkg::ACC_W-1:0]   acc,
   input  logic signed [dda_pkg::ACC_W-1:0]   hold,
   output dda_pkg::alu_res_type               res
);
   localparam int ACC_W = dda_pkg::ACC_W;

   logic signed [ACC_W-1:0] opa;
   logic signed [ACC_W-1:0] opb;
   logic signed [ACC_W-1:0] year_days;
   logic signed [ACC_W-1:0] mon_days;
   logic                    sub;

   assign year_days = ctl.leap ? ACC_W'(366) : ACC_W'(365);
   assign mon_days  = ACC_W'(dda_pkg::month_len(ctl.month, ctl.leap));

   always_comb begin
      opa = acc;
      opb = '0;
      sub = 1'b0;
      unique case (ctl.op)
         dda_pkg::ALU_PASS:     opb = '0;
         dda_pkg::ALU_BLK_ADD:  opb = ACC_W'(dda_pkg::BLOCK_DAYS);
         dda_pkg::ALU_YEAR_ADD: opb = year_days;
         dda_pkg::ALU_MON_ADD:  opb = mon_days;
         dda_pkg::ALU_DAY_ADD:  opb = ACC_W'(ctl.day) - ACC_W'(1);
         dda_pkg::ALU_CNT_ADD:  opb = ACC_W'(ctl.cnt);
         dda_pkg::ALU_CNT_SUB: begin
            opb = ACC_W'(ctl.cnt);
            sub = 1'b1;
         end
         dda_pkg::ALU_DIFF: begin
            opa = hold;
            opb = acc;
            sub = 1'b1;
         end
         dda_pkg::ALU_BLK_SUB: begin
            opb = ACC_W'(dda_pkg::BLOCK_DAYS);
            sub = 1'b1;
         end
         dda_pkg::ALU_YEAR_SUB: begin
            opb = year_days;
            sub = 1'b1;
         end
         dda_pkg::ALU_MON_SUB: begin
            opb = mon_days;
            sub = 1'b1;
         end
         default: opb = '0;
      endcase
      res.sum = sub ? (opa - opb) : (opa + opb);
      res.neg = res.sum[ACC_W-1];
   end

endmodule

// ----- design/date_day_arithmetic.sv -----
// date arithmetic top level: sequencer around one shared day adder
// the day number of a date is found by walking 400-year blocks, then single years, then the
// months before its month; difference does that twice, add and subtract then walk the
// moved day number back the same way
// throughput: one word at a time, a new request is taken only after the response is taken
// reset: synchronous, active high, returns the sequencer to idle; data registers keep values
module date_day_arithmetic #(
   parameter int YEAR_MAX = dda_pkg::YEAR_MAX_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   dda_req_if.sink    req_ch,
   dda_rsp_if.source  rsp_ch
);
   localparam int ACC_W      = dda_pkg::ACC_W;
   localparam int YEAR_CNT_W = dda_pkg::YEAR_CNT_W;
   localparam int DAY_W      = dda_pkg::DAY_W;
   localparam int MONTH_W    = dda_pkg::MONTH_W;
   localparam int YEAR_W     = dda_pkg::YEAR_W;
   localparam int DIFF_W     = dda_pkg::DIFF_W;
   localparam int STAT_W     = dda_pkg::STAT_W;
   // last year allowed, clipped to what the year field can hold
   localparam int YEAR_LIMIT = (YEAR_MAX < dda_pkg::FIELD_YEAR_TOP) ?
                               YEAR_MAX : dda_pkg::FIELD_YEAR_TOP;
   localparam logic [YEAR_CNT_W-1:0] LIMIT_Y = YEAR_CNT_W'(YEAR_LIMIT);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_OYEAR = 11'b000_0000_0010,  // walk 400-year blocks then years up to the target
      S_OMON  = 11'b000_0000_0100,  // walk months before the target month
      S_CHECK = 11'b000_0000_1000,  // check the date, add the day of month less one
      S_DIFF  = 11'b000_0001_0000,
      S_MOVE  = 11'b000_0010_0000,
      S_FBLK  = 11'b000_0100_0000,  // peel 400-year blocks off the moved day number
      S_FYEAR = 11'b000_1000_0000,
      S_FMON  = 11'b001_0000_0000,
      S_DONE  = 11'b010_0000_0000,
      S_SPARE = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // request and walker registers
   logic [dda_pkg::TYPE_W-1:0]  op_ff, op_in;
   logic [DAY_W-1:0]            td_ff, td_in;       // day of the date being walked
   logic [MONTH_W-1:0]          tm_ff, tm_in;
   logic [YEAR_W-1:0]           ty_ff, ty_in;
   logic [dda_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [DAY_W-1:0]            d2_ff, d2_in;
   logic [MONTH_W-1:0]          m2_ff, m2_in;
   logic [YEAR_W-1:0]           y2_ff, y2_in;
   logic                        second_ff, second_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;     // running day number
   logic signed [ACC_W-1:0]     o1_ff, o1_in;       // day number of the first date
   logic [YEAR_CNT_W-1:0]       yw_ff, yw_in;       // year walker
   logic [8:0]                  c400_ff, c400_in;   // walker year mod 400
   logic [6:0]                  c100_ff, c100_in;   // walker year mod 100
   logic [MONTH_W-1:0]          mc_ff, mc_in;       // month walker

   // response registers
   logic [DAY_W-1:0]            rday_ff, rday_in;
   logic [MONTH_W-1:0]          rmon_ff, rmon_in;
   logic [YEAR_W-1:0]           ryear_ff, ryear_in;
   logic signed [DIFF_W-1:0]    rdiff_ff, rdiff_in;
   logic [STAT_W-1:0]           rstat_ff, rstat_in;

   dda_pkg::alu_ctl_type alu_ctl;
   dda_pkg::alu_res_type alu_res;

   logic                  leap;
   logic [YEAR_CNT_W-1:0] year_gap;
   logic                  date_ok;
   logic [8:0]            c400_inc;
   logic [6:0]            c100_inc;

   dda_alu u_alu (
      .ctl  (alu_ctl),
      .acc  (acc_ff),
      .hold (o1_ff),
      .res  (alu_res)
   );

   // leap year from the walker's residues
   assign leap = (c400_ff == 9'd0) || ((c400_ff[1:0] == 2'd0) && (c100_ff != 7'd0));

   assign c400_inc = (c400_ff == 9'(dda_pkg::BLOCK_YEARS - 1)) ? 9'd0 : c400_ff + 9'd1;
   assign c100_inc = (c100_ff == 7'(dda_pkg::CENTURY_YEARS - 1)) ? 7'd0 : c100_ff + 7'd1;

   // years still to walk toward the target year
   assign year_gap = YEAR_CNT_W'(ty_ff) - yw_ff;

   assign date_ok = (YEAR_CNT_W'(ty_ff) <= LIMIT_Y) && (tm_ff != 4'd0) &&
                    (tm_ff <= 4'(dda_pkg::MONTHS_PER_YEAR)) && (td_ff != 5'd0) &&
                    (td_ff <= dda_pkg::month_len(tm_ff, leap));

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = (state_ff == S_DONE);
   assign rsp_ch.out_day        = rday_ff;
   assign rsp_ch.out_month      = rmon_ff;
   assign rsp_ch.out_year       = ryear_ff;
   assign rsp_ch.day_difference = rdiff_ff;
   assign rsp_ch.status         = rstat_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      td_in     = td_ff;
      tm_in     = tm_ff;
      ty_in     = ty_ff;
      cnt_in    = cnt_ff;
      d2_in     = d2_ff;
      m2_in     = m2_ff;
      y2_in     = y2_ff;
      second_in = second_ff;
      acc_in    = acc_ff;
      o1_in     = o1_ff;
      yw_in     = yw_ff;
      c400_in   = c400_ff;
      c100_in   = c100_ff;
      mc_in     = mc_ff;
      rday_in   = rday_ff;
      rmon_in   = rmon_ff;
      ryear_in  = ryear_ff;
      rdiff_in  = rdiff_ff;
      rstat_in  = rstat_ff;

      alu_ctl.op    = dda_pkg::ALU_PASS;
      alu_ctl.leap  = leap;
      alu_ctl.month = mc_ff;
      alu_ctl.day   = td_ff;
      alu_ctl.cnt   = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               // latch the word and start on the first date's day number
               op_in     = req_ch.req_type;
               td_in     = req_ch.day;
               tm_in     = req_ch.month;
               ty_in     = req_ch.year;
               cnt_in    = req_ch.day_count;
               d2_in     = req_ch.other_day;
               m2_in     = req_ch.other_month;
               y2_in     = req_ch.other_year;
               second_in = 1'b0;
               acc_in    = '0;
               yw_in     = '0;
               c400_in   = '0;
               c100_in   = '0;
               mc_in     = 4'd1;
               state_in  = S_OYEAR;
            end
         end

         S_OYEAR: begin
            if (year_gap >= YEAR_CNT_W'(dda_pkg::BLOCK_YEARS)) begin
               // whole 400-year block, residues stay at zero
               alu_ctl.op = dda_pkg::ALU_BLK_ADD;
               acc_in     = alu_res.sum;
               yw_in      = yw_ff + YEAR_CNT_W'(dda_pkg::BLOCK_YEARS);
            end else if (year_gap != '0) begin
               alu_ctl.op = dda_pkg::ALU_YEAR_ADD;
               acc_in     = alu_res.sum;
               yw_in      = yw_ff + YEAR_CNT_W'(1);
               c400_in    = c400_inc;
               c100_in    = c100_inc;
            end else begin
               state_in = S_OMON;
            end
         end

         S_OMON: begin
            if (mc_ff < tm_ff) begin
               alu_ctl.op = dda_pkg::ALU_MON_ADD;
               acc_in     = alu_res.sum;
               mc_in      = mc_ff + 4'd1;
            end else begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            alu_ctl.op = dda_pkg::ALU_DAY_ADD;
            if (!date_ok) begin
               rday_in  = '0;
               rmon_in  = '0;
               ryear_in = '0;
               rdiff_in = '0;
               rstat_in = dda_pkg::STATUS_INVALID;
               state_in = S_DONE;
            end else if (op_ff == dda_pkg::OP_CHECK) begin
               rday_in  = td_ff;
               rmon_in  = tm_ff;
               ryear_in = ty_ff;
               rdiff_in = '0;
               rstat_in = dda_pkg::STATUS_OK;
               state_in = S_DONE;
            end else if ((op_ff == dda_pkg::OP_DIFF) && !second_ff) begin
               // keep the first day number, walk the second date
               o1_in     = alu_res.sum;
               second_in = 1'b1;
               td_in     = d2_ff;
               tm_in     = m2_ff;
               ty_in     = y2_ff;
               acc_in    = '0;
               yw_in     = '0;
               c400_in   = '0;
               c100_in   = '0;
               mc_in     = 4'd1;
               state_in  = S_OYEAR;
            end else if (op_ff == dda_pkg::OP_DIFF) begin
               acc_in   = alu_res.sum;
               state_in = S_DIFF;
            end else begin
               acc_in   = alu_res.sum;
               state_in = S_MOVE;
            end
         end

         S_DIFF: begin
            alu_ctl.op = dda_pkg::ALU_DIFF;
            rday_in    = '0;
            rmon_in    = '0;
            ryear_in   = '0;
            rstat_in   = dda_pkg::STATUS_OK;
            // clamp to the difference field
            if (alu_res.sum > dda_pkg::DIFF_HIGH) begin
               rdiff_in = dda_pkg::DIFF_HIGH[DIFF_W-1:0];
            end else if (alu_res.sum < dda_pkg::DIFF_LOW) begin
               rdiff_in = dda_pkg::DIFF_LOW[DIFF_W-1:0];
            end else begin
               rdiff_in = alu_res.sum[DIFF_W-1:0];
            end
            state_in = S_DONE;
         end

         S_MOVE: begin
            alu_ctl.op = (op_ff == dda_pkg::OP_ADD) ? dda_pkg::ALU_CNT_ADD
                                                    : dda_pkg::ALU_CNT_SUB;
            acc_in   = alu_res.sum;
            yw_in    = '0;
            c400_in  = '0;
            c100_in  = '0;
            state_in = S_FBLK;
         end

         S_FBLK: begin
            alu_ctl.op = dda_pkg::ALU_BLK_SUB;
            if (acc_ff[ACC_W-1]) begin
               // moved before the first day of year zero
               rday_in  = '0;
               rmon_in  = '0;
               ryear_in = '0;
               rdiff_in = '0;
               rstat_in = dda_pkg::STATUS_RANGE;
               state_in = S_DONE;
            end else if (!alu_res.neg) begin
               acc_in = alu_res.sum;
               yw_in  = yw_ff + YEAR_CNT_W'(dda_pkg::BLOCK_YEARS);
            end else begin
               state_in = S_FYEAR;
            end
         end

         S_FYEAR: begin
            alu_ctl.op = dda_pkg::ALU_YEAR_SUB;
            if (!alu_res.neg) begin
               acc_in  = alu_res.sum;
               yw_in   = yw_ff + YEAR_CNT_W'(1);
               c400_in = c400_inc;
               c100_in = c100_inc;
            end else if (yw_ff > LIMIT_Y) begin
               rday_in  = '0;
               rmon_in  = '0;
               ryear_in = '0;
               rdiff_in = '0;
               rstat_in = dda_pkg::STATUS_RANGE;
               state_in = S_DONE;
            end else begin
               mc_in    = 4'd1;
               state_in = S_FMON;
            end
         end

         S_FMON: begin
            alu_ctl.op = dda_pkg::ALU_MON_SUB;
            if (!alu_res.neg && (mc_ff < 4'(dda_pkg::MONTHS_PER_YEAR))) begin
               acc_in = alu_res.sum;
               mc_in  = mc_ff + 4'd1;
            end else begin
               // remainder is the day of month less one
               rday_in  = acc_ff[DAY_W-1:0] + 5'd1;
               rmon_in  = mc_ff;
               ryear_in = yw_ff[YEAR_W-1:0];
               rdiff_in = '0;
               rstat_in = dda_pkg::STATUS_OK;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      td_ff     <= td_in;
      tm_ff     <= tm_in;
      ty_ff     <= ty_in;
      cnt_ff    <= cnt_in;
      d2_ff     <= d2_in;
      m2_ff     <= m2_in;
      y2_ff     <= y2_in;
      second_ff <= second_in;
      acc_ff    <= acc_in;
      o1_ff     <= o1_in;
      yw_ff     <= yw_in;
      c400_ff   <= c400_in;
      c100_ff   <= c100_in;
      mc_ff     <= mc_in;
      rday_ff   <= rday_in;
      rmon_ff   <= rmon_in;
      ryear_ff  <= ryear_in;
      rdiff_ff  <= rdiff_in;
      rstat_ff  <= rstat_in;
   end

   // a request is never taken while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while response pending");

   // an accepted word keeps the sequencer busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("sequencer not busy after accept");

   // an error response carries all-zero result fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status != dda_pkg::STATUS_OK) |->
         (rsp_ch.out_day == '0) && (rsp_ch.out_month == '0) &&
         (rsp_ch.out_year == '0) && (rsp_ch.day_difference == '0))
      else $error("error response with nonzero fields");

   // a successful move lands on a real month and day
   a_move_date: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == dda_pkg::STATUS_OK) &&
      ((op_ff == dda_pkg::OP_ADD) || (op_ff == dda_pkg::OP_SUB)) |->
         (rsp_ch.out_month != '0) && (rsp_ch.out_month <= 4'(dda_pkg::MONTHS_PER_YEAR)) &&
         (rsp_ch.out_day != '0))
      else $error("moved date out of calendar");

endmodule
